/* sv/stk_pkg.sv */
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants of the stack block
// Field widths, request and status codes, controller states, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package stk_pkg;

  localparam int VALUE_W  = 32;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REVERSE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SORT    = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP_RD,
    ST_POP_CAP,
    ST_REV_RD_LO,
    ST_REV_RD_HI,
    ST_REV_WR_LO,
    ST_REV_WR_HI,
    ST_SORT_RD_I,
    ST_SORT_CAP,
    ST_SORT_RD_J,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_FINISH
  } fsm_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP_RD,
    OP_POP_CAP,
    OP_REV_RD_LO,
    OP_REV_RD_HI,
    OP_REV_WR_LO,
    OP_REV_WR_HI,
    OP_SORT_RD_I,
    OP_SORT_CAP,
    OP_SORT_RD_J,
    OP_SORT_SHIFT,
    OP_SORT_WR
  } dp_op_t;

  typedef struct packed {
    logic   take_in;
    dp_op_t op;
    logic   emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic level_zero;
    logic lo_lt_hi;
    logic i_lt_level;
    logic j_zero;
    logic greater;
    logic out_free;
  } stat_t;

endpackage

/* sv/stk_req_if.sv */
// ----------------------------------------------------------------------------
// stk_req_if: request channel
// Carries one request item: request type and the value to push.
// ----------------------------------------------------------------------------
interface stk_req_if
  import stk_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic        [REQ_W-1:0]   req_type;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

/* sv/stk_rsp_if.sv */
// ----------------------------------------------------------------------------
// stk_rsp_if: result channel
// Carries one result item: popped value, status and fill level.
// ----------------------------------------------------------------------------
interface stk_rsp_if
  import stk_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  pop_value;
  logic        [STATUS_W-1:0] status;
  logic        [FILL_W-1:0]   fill_level;

  modport source (output valid, output pop_value, output status, output fill_level,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input fill_level,
                  output ready);
endinterface

/* sv/stk_cfg_if.sv */
// ----------------------------------------------------------------------------
// stk_cfg_if: configuration write channel
// Carries a new value of the stack limit register.
// ----------------------------------------------------------------------------
interface stk_cfg_if
  import stk_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] stack_limit;

  modport source (output valid, output stack_limit, input ready);
  modport sink   (input valid, input stack_limit, output ready);
endinterface

/* sv/stk_ram.sv */
// ----------------------------------------------------------------------------
// stk_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/stk_ctrl.sv */
// ----------------------------------------------------------------------------
// stk_ctrl: request sequencer
// Steps each request through push, pop, reverse or insertion sort, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module stk_ctrl
  import stk_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [REQ_W-1:0] req_type,
  input  stat_t            stat,
  output logic             in_ready,
  output cmd_t             cmd
);

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (req_type)
            REQ_PUSH:    state_next = ST_PUSH;
            REQ_POP:     state_next = ST_POP_RD;
            REQ_REVERSE: state_next = ST_REV_RD_LO;
            default:     state_next = ST_SORT_RD_I;
          endcase
        end
      end
      ST_PUSH:      state_next = ST_FINISH;
      ST_POP_RD:    state_next = stat.level_zero ? ST_FINISH : ST_POP_CAP;
      ST_POP_CAP:   state_next = ST_FINISH;
      ST_REV_RD_LO: state_next = stat.lo_lt_hi ? ST_REV_RD_HI : ST_FINISH;
      ST_REV_RD_HI: state_next = ST_REV_WR_LO;
      ST_REV_WR_LO: state_next = ST_REV_WR_HI;
      ST_REV_WR_HI: state_next = ST_REV_RD_LO;
      ST_SORT_RD_I: state_next = stat.i_lt_level ? ST_SORT_CAP : ST_FINISH;
      ST_SORT_CAP:  state_next = ST_SORT_RD_J;
      ST_SORT_RD_J: state_next = stat.j_zero ? ST_SORT_WR : ST_SORT_CMP;
      ST_SORT_CMP:  state_next = stat.greater ? ST_SORT_RD_J : ST_SORT_WR;
      ST_SORT_WR:   state_next = ST_SORT_RD_I;
      ST_FINISH:    state_next = stat.out_free ? ST_IDLE : ST_FINISH;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    // No item is taken while reset is held, so none can be lost there.
    in_ready    = (state == ST_IDLE) && !rst;
    cmd.take_in = (state == ST_IDLE) && !rst && in_valid;
    cmd.emit    = (state == ST_FINISH) && stat.out_free;
    cmd.op      = OP_NONE;
    case (state)
      ST_PUSH:      cmd.op = OP_PUSH;
      ST_POP_RD:    cmd.op = OP_POP_RD;
      ST_POP_CAP:   cmd.op = OP_POP_CAP;
      ST_REV_RD_LO: cmd.op = stat.lo_lt_hi ? OP_REV_RD_LO : OP_NONE;
      ST_REV_RD_HI: cmd.op = OP_REV_RD_HI;
      ST_REV_WR_LO: cmd.op = OP_REV_WR_LO;
      ST_REV_WR_HI: cmd.op = OP_REV_WR_HI;
      ST_SORT_RD_I: cmd.op = stat.i_lt_level ? OP_SORT_RD_I : OP_NONE;
      ST_SORT_CAP:  cmd.op = OP_SORT_CAP;
      ST_SORT_RD_J: cmd.op = stat.j_zero ? OP_NONE : OP_SORT_RD_J;
      ST_SORT_CMP:  cmd.op = stat.greater ? OP_SORT_SHIFT : OP_NONE;
      ST_SORT_WR:   cmd.op = OP_SORT_WR;
      default:      cmd.op = OP_NONE;
    endcase
  end

  a_push_dispatch: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == REQ_PUSH |=> state == ST_PUSH)
    else $error("push request did not go to the push step");

  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && !stat.out_free |=> state == ST_FINISH)
    else $error("result left before the output register was free");

  a_sort_shift: assert property (@(posedge clk) disable iff (rst)
    state == ST_SORT_CMP && stat.greater |=> state == ST_SORT_RD_J)
    else $error("sort shift did not continue the inner scan");

endmodule

/* sv/stk_dp.sv */
// ----------------------------------------------------------------------------
// stk_dp: stack datapath
// Holds the fill level, limit, scan indexes and the result and output
// registers, and drives the entry store.
// ----------------------------------------------------------------------------
module stk_dp
  import stk_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic        [REQ_W-1:0]   req_type,
  input  logic signed [VALUE_W-1:0] push_value,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  stk_rsp_if.source                 rsp,
  stk_cfg_if.sink                   cfg
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;

  logic        [LW-1:0]       level;
  logic        [LIMIT_W-1:0]  limit;
  logic        [LW-1:0]       ia;
  logic        [AW-1:0]       ib;
  logic signed [VALUE_W-1:0]  val;
  logic signed [VALUE_W-1:0]  tmp;
  logic signed [VALUE_W-1:0]  res_value;
  logic        [STATUS_W-1:0] res_status;

  logic        [LW-1:0]       level_m1;
  logic        [CW-1:0]       lim_ext;
  logic        [CW-1:0]       eff_limit;
  logic                       mem_we;
  logic        [AW-1:0]       mem_waddr;
  logic        [VALUE_W-1:0]  mem_wdata;
  logic        [AW-1:0]       mem_raddr;
  logic signed [VALUE_W-1:0]  mem_rdata;

  stk_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign level_m1  = level - LW'(1);
  assign lim_ext   = CW'(limit);
  assign eff_limit = (lim_ext > CW'(DEPTH)) ? CW'(DEPTH) : lim_ext;

  assign stat.full       = CW'(level) >= eff_limit;
  assign stat.level_zero = (level == '0);
  assign stat.lo_lt_hi   = ia < LW'(ib);
  assign stat.i_lt_level = ia < level;
  assign stat.j_zero     = (ib == '0);
  assign stat.greater    = tmp > mem_rdata;
  assign stat.out_free   = !rsp.valid || rsp.ready;

  // Limit writes are refused while reset is held.
  assign cfg.ready = !rst;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ib;
    mem_wdata = mem_rdata;
    mem_raddr = ia[AW-1:0];
    case (cmd.op)
      OP_PUSH: begin
        mem_we    = !stat.full;
        mem_waddr = level[AW-1:0];
        mem_wdata = val;
      end
      OP_POP_RD:     mem_raddr = level_m1[AW-1:0];
      OP_REV_RD_HI:  mem_raddr = ib;
      OP_REV_WR_LO: begin
        mem_we    = 1'b1;
        mem_waddr = ia[AW-1:0];
      end
      OP_REV_WR_HI: begin
        mem_we    = 1'b1;
        mem_wdata = tmp;
      end
      OP_SORT_RD_J:  mem_raddr = ib - AW'(1);
      OP_SORT_SHIFT: mem_we = 1'b1;
      OP_SORT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = tmp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      limit     <= LIMIT_RESET;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        limit <= cfg.stack_limit;
      end
      if (cmd.op == OP_PUSH && !stat.full) begin
        level <= level + LW'(1);
      end
      if (cmd.op == OP_POP_CAP) begin
        level <= level_m1;
      end
      if (cmd.emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      val        <= push_value;
      res_value  <= '0;
      res_status <= STATUS_DONE;
      ia         <= (req_type == REQ_SORT) ? LW'(1) : '0;
      ib         <= stat.level_zero ? '0 : level_m1[AW-1:0];
    end
    case (cmd.op)
      OP_PUSH: begin
        if (stat.full) begin
          res_status <= STATUS_FULL;
        end
      end
      OP_POP_RD: begin
        if (stat.level_zero) begin
          res_value  <= -32'sd1;
          res_status <= STATUS_EMPTY;
        end
      end
      OP_POP_CAP:   res_value <= mem_rdata;
      OP_REV_RD_HI: tmp <= mem_rdata;
      OP_REV_WR_HI: begin
        ia <= ia + LW'(1);
        ib <= ib - AW'(1);
      end
      OP_SORT_CAP: begin
        tmp <= mem_rdata;
        ib  <= ia[AW-1:0];
      end
      OP_SORT_SHIFT: ib <= ib - AW'(1);
      OP_SORT_WR:    ia <= ia + LW'(1);
      default: ;
    endcase
    if (cmd.emit) begin
      rsp.pop_value  <= res_value;
      rsp.status     <= res_status;
      rsp.fill_level <= FILL_W'(level);
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LW'(DEPTH))
    else $error("fill level beyond the store depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_PUSH && !stat.full |=> level == $past(level) + LW'(1))
    else $error("accepted push did not raise the fill level");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_POP_CAP |-> !stat.level_zero)
    else $error("pop capture on an empty stack");

endmodule

/* sv/stack_with_sort_and_reverse.sv */
// ----------------------------------------------------------------------------
// stack_with_sort_and_reverse: bounded LIFO stack with reverse and sort
// A push passes through the push and finish steps; a pop through the read,
// capture (skipped when the stack is empty) and finish steps. Reverse and sort
// walk the store entry by entry. No new item is taken until the result has
// entered the output register; the store's single
// registered read port paces the walks. Reset clears the fill level and the result
// valid flag and sets the limit to 16; no item is taken during reset.
// ----------------------------------------------------------------------------
module stack_with_sort_and_reverse
  import stk_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  stk_req_if.sink   req,
  stk_rsp_if.source rsp,
  stk_cfg_if.sink   cfg
);

  // The controller walks each request item through its steps; the datapath
  // owns the fill level, the limit register, the entry store and the output
  // register. They exchange only the command and status bundles below.
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  // A new request item is taken only while the controller is idle. A finished
  // result sits in the output register, so the next item may be taken while
  // the previous result still waits on the result channel.
  assign req.ready = in_ready;

  stk_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .req_type(req.req_type),
    .stat    (stat),
    .in_ready(in_ready),
    .cmd     (cmd)
  );

  // Pushes beyond the limit are dropped and flagged; the limit saturates at
  // the store depth. Reverse swaps entries from both ends inward, and sort is
  // an insertion sort that leaves the smallest value on top.
  stk_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_type  (req.req_type),
    .push_value(req.push_value),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp),
    .cfg       (cfg)
  );

endmodule

/* bench/tb_stack_with_sort_and_reverse.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_with_sort_and_reverse: self-checking bench of the sorting stack
// Drives push, pop, reverse and sort requests under several stack limits,
// tracks the expected stack contents in a scoreboard and compares every
// result item field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_stack_with_sort_and_reverse;
  import stk_pkg::*;

  localparam int STORE_DEPTH    = 16;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHASES     = 9;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  pop_value;
    logic        [STATUS_W-1:0] status;
    logic        [FILL_W-1:0]   fill_level;
  } stack_result_t;

  // The scoreboard keeps its own copy of the stack and of the limit register.
  // Each accepted request is applied to that copy at once, and the result it
  // must produce is queued; results leave the block in request order.
  class stack_scoreboard;
    logic signed [VALUE_W-1:0] entries [STORE_DEPTH];
    int unsigned               level;
    int unsigned               limit;
    stack_result_t             awaited_results [$];
    int                        errors;

    function new();
      level  = 0;
      limit  = LIMIT_RESET;
      errors = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    // A limit above the store depth behaves as the depth itself.
    function int unsigned held_max();
      return (limit > STORE_DEPTH) ? STORE_DEPTH : limit;
    endfunction

    function void reverse_entries();
      logic signed [VALUE_W-1:0] swap;
      int unsigned lo;
      int unsigned hi;
      lo = 0;
      hi = level;
      while (hi > lo + 1) begin
        hi--;
        swap        = entries[lo];
        entries[lo] = entries[hi];
        entries[hi] = swap;
        lo++;
      end
    endfunction

    // Insertion sort that leaves the largest value at the bottom (entry 0)
    // and the smallest on top.
    function void sort_entries();
      logic signed [VALUE_W-1:0] pick;
      int j;
      for (int i = 1; i < int'(level); i++) begin
        pick = entries[i];
        j    = i;
        while (j > 0 && pick > entries[j-1]) begin
          entries[j] = entries[j-1];
          j--;
        end
        entries[j] = pick;
      end
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic signed [VALUE_W-1:0] value);
      stack_result_t outcome;
      outcome.pop_value = '0;
      outcome.status    = STATUS_DONE;
      case (kind)
        REQ_PUSH: begin
          // Pushes are dropped whenever the stack holds the limit or more,
          // which also covers a limit lowered below the current level.
          if (level >= held_max()) begin
            outcome.status = STATUS_FULL;
          end else begin
            entries[level] = value;
            level++;
          end
        end
        REQ_POP: begin
          if (level == 0) begin
            outcome.pop_value = -1;
            outcome.status    = STATUS_EMPTY;
          end else begin
            level--;
            outcome.pop_value = entries[level];
          end
        end
        REQ_REVERSE: begin
          reverse_entries();
        end
        default: begin
          sort_entries();
        end
      endcase
      outcome.fill_level = FILL_W'(level);
      awaited_results.push_back(outcome);
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] pop_value,
                               logic [STATUS_W-1:0] status, logic [FILL_W-1:0] fill_level);
      stack_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result item with no request outstanding");
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (pop_value !== want.pop_value) begin
        $error("pop_value: expected %0d, got %0d", want.pop_value, pop_value);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (fill_level !== want.fill_level) begin
        $error("fill_level: expected %0d, got %0d", want.fill_level, fill_level);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  stk_req_if req_ch ();
  stk_rsp_if rsp_ch ();
  stk_cfg_if cfg_ch ();

  stack_with_sort_and_reverse i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  stack_scoreboard sb = new();

  // Chance in percent that either side inserts an idle burst before its
  // next item. The main sequence changes it per phase; zero means no idling.
  int          idle_pct     = 20;
  int unsigned quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // All three monitors sample at the rising edge, before the nonblocking
  // updates of that edge land, so they see the values the block saw.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      sb.note_request(req_ch.req_type, req_ch.push_value);
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result(rsp_ch.pop_value, rsp_ch.status, rsp_ch.fill_level);
    end
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      sb.set_limit(cfg_ch.stack_limit);
    end
  end

  // The watchdog ends the run after a long stretch in which no channel
  // moves an item. The slowest legal stretch is a sort of a full stack
  // plus the idle bursts around it.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_stack_with_sort_and_reverse failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: ready drops in idle bursts at random.
  initial begin
    int hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        hold = $urandom_range(1, 3);
      end
      rsp_ch.ready <= (hold == 0);
    end
  end

  // Offers one request item and returns at the edge where it is accepted.
  // Valid is left high so that the next call can follow back to back.
  task automatic issue_request(input logic [REQ_W-1:0] kind,
                               input logic signed [VALUE_W-1:0] value);
    int gap;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      gap = $urandom_range(1, 3);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.push_value <= value;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Waits until every result has come back and the block has settled.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The limit register is only written while the block is idle.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain_results();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.stack_limit <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mix of extreme words, a narrow band that makes equal values common
  // under sort, and fully random words.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 4))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return -1;
        3:       return 0;
        default: return 1;
      endcase
    end else if (roll < 35) begin
      return $signed($urandom_range(0, 16)) - 8;
    end
    return $signed($urandom());
  endfunction

  // Random requests in alternating fill and drain stretches, so that the
  // stack swings between empty and its limit with sorts and reversals of
  // every size in between.
  task automatic run_mixed(input int count);
    int          stretch;
    bit          filling;
    int unsigned roll;
    logic [REQ_W-1:0] kind;
    stretch = 0;
    filling = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (stretch == 0) begin
        filling = ~filling;
        stretch = $urandom_range(10, 40);
      end
      stretch--;
      roll = $urandom_range(0, 99);
      if (roll < (filling ? 60 : 25)) begin
        kind = REQ_PUSH;
      end else if (roll < 85) begin
        kind = REQ_POP;
      end else if (roll < 92) begin
        kind = REQ_REVERSE;
      end else begin
        kind = REQ_SORT;
      end
      // Non-push requests still carry random data, which must be ignored.
      issue_request(kind, pick_value());
    end
  endtask

  initial begin
    int phase_limit [NUM_PHASES];
    int phase_items [NUM_PHASES];
    int phase_idle  [NUM_PHASES];

    // The first phases cover the saturating top of the limit range and the
    // reset value; the last phase runs without any idling.
    phase_limit = '{31, 16, 1, 5, 0, 9, 17, 2, 16};
    phase_items = '{220, 220, 180, 200, 40, 200, 200, 180, 240};
    phase_idle  = '{20, 35, 20, 0, 20, 30, 10, 25, 0};

    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_PUSH;
    req_ch.push_value   = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.stack_limit  = LIMIT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset limit: every request on an empty stack,
    // reverse and sort of a single entry, the extremes of the value range
    // and a duplicate under sort.
    issue_request(REQ_POP, 0);
    issue_request(REQ_REVERSE, 0);
    issue_request(REQ_SORT, 0);
    issue_request(REQ_PUSH, 32'sh7FFF_FFFF);
    issue_request(REQ_REVERSE, 32'sh1234_5678);
    issue_request(REQ_SORT, -1);
    issue_request(REQ_PUSH, 32'sh8000_0000);
    issue_request(REQ_PUSH, -1);
    issue_request(REQ_PUSH, 0);
    issue_request(REQ_PUSH, 1);
    issue_request(REQ_PUSH, 32'sh8000_0000);
    issue_request(REQ_SORT, 0);
    issue_request(REQ_POP, 0);
    issue_request(REQ_REVERSE, 0);
    issue_request(REQ_POP, 0);
    issue_request(REQ_POP, 0);

    // Limit lowered below the three entries still held: the push is dropped,
    // while sort and pop still act on all three entries.
    write_limit(5'd1);
    issue_request(REQ_PUSH, 42);
    issue_request(REQ_SORT, 0);
    issue_request(REQ_POP, 0);
    issue_request(REQ_POP, 0);
    issue_request(REQ_POP, 0);

    // A limit of zero drops every push.
    write_limit(5'd0);
    issue_request(REQ_PUSH, 5);
    issue_request(REQ_POP, 0);

    // Random phases. Every limit change waits for the block to drain, so the
    // sender pauses there until all outstanding results have come back.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(LIMIT_W'(phase_limit[p]));
      idle_pct = phase_idle[p];
      run_mixed(phase_items[p]);
    end

    drain_results();
    if (sb.pending() != 0) begin
      $error("%0d expected result items never arrived", sb.pending());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("tb_stack_with_sort_and_reverse passed");
    end else begin
      $display("tb_stack_with_sort_and_reverse failed");
    end
    $finish;
  end

endmodule
